[hdl/mer_pkg.sv]
// shared types and constants for the midpoint ellipse rasterizer
package mer_pkg;

	// default coordinate width of the rectangle edges
	localparam int COORD_BITS_DEF = 12;

	// width of one emitted coordinate and number of coordinates per result
	localparam int OUT_BITS   = 14;
	localparam int OUT_FIELDS = 8;
	localparam int OUT_W      = OUT_BITS * OUT_FIELDS;

	// request kinds carried in tuser
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT_SQ,
		ST_INIT_PROD,
		ST_WT,
		ST_VEL,
		ST_UPD
	} state_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT_SQ,
		OP_INIT_PROD,
		OP_SQ,
		OP_WT,
		OP_VEL,
		OP_UPD
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic active;
		logic slot_free;
	} dp_status_t;

endpackage

[hdl/mer_ctrl.sv]
// controller state machine sequencing the shared multipliers
module mer_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	output logic                in_ready,
	input  mer_pkg::dp_status_t status,
	output mer_pkg::dp_cmd_t    cmd
);
	import mer_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	// requests are taken only while idle
	assign accept = in_valid && (state_q == ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_kind == KIND_START) begin
					state_nxt = ST_INIT_SQ;
				end else if (accept && in_kind == KIND_STEP && status.active) begin
					state_nxt = ST_WT;
				end
			end
			ST_INIT_SQ:   state_nxt = ST_INIT_PROD;
			ST_INIT_PROD: state_nxt = ST_IDLE;
			ST_WT:        state_nxt = ST_VEL;
			ST_VEL:       state_nxt = ST_UPD;
			ST_UPD: begin
				if (status.slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:      state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept && in_kind == KIND_START) begin
					cmd.op = OP_LOAD;
				end else if (accept && in_kind == KIND_STEP && status.active) begin
					cmd.op = OP_SQ;
				end
			end
			ST_INIT_SQ:   cmd.op = OP_INIT_SQ;
			ST_INIT_PROD: cmd.op = OP_INIT_PROD;
			ST_WT:        cmd.op = OP_WT;
			ST_VEL:       cmd.op = OP_VEL;
			ST_UPD: begin
				if (status.slot_free) begin
					cmd.op = OP_UPD;
				end
			end
			default:      cmd.op = OP_NONE;
		endcase
	end

endmodule

[hdl/mer_dpath.sv]
// ellipse state, two shared multipliers, decision logic and output register
module mer_dpath #(
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mer_pkg::dp_cmd_t           cmd,
	output mer_pkg::dp_status_t        status,
	input  logic [COORD_BITS-1:0]      rect_left,
	input  logic [COORD_BITS-1:0]      rect_top,
	input  logic [COORD_BITS-1:0]      rect_right,
	input  logic [COORD_BITS-1:0]      rect_bottom,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [mer_pkg::OUT_W-1:0]  out_data,
	output logic                       out_last
);
	import mer_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int CW  = C + 1;          // center and dx
	localparam int YW  = C + 2;          // signed dy
	localparam int MW  = C + 2;          // magnitude of the doubled midpoint terms
	localparam int SQW = 2 * C + 2;      // their squares
	localparam int AW  = 2 * C;          // squared semi-axes
	localparam int PW  = AW + SQW;       // multiplier product
	localparam int DW  = PW + 2;         // signed discriminant
	localparam int EW  = (C + 3 > OUT_BITS) ? C + 3 : OUT_BITS;

	// ellipse state
	logic [CW-1:0]        cx_q, cy_q;
	logic [C-1:0]         a_q, b_q;
	logic [CW-1:0]        dx_q;
	logic signed [YW-1:0] dy_q;
	logic                 r2_q;
	logic                 active_q;

	// intermediate products
	logic [AW-1:0]  a2_q, b2_q;
	logic [PW-1:0]  ab_q;
	logic [SQW-1:0] su_q, sv_q;
	logic [PW-1:0]  pu_q, pv_q;
	logic [PW-1:0]  vx_q, vy_q;
	logic           dneg_q;

	// output register
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              out_last_q;

	// rectangle sorting for a start request
	logic [C-1:0]  lx, hx, ly, hy;
	logic [CW-1:0] ext_x, ext_y, sum_x, sum_y;

	always_comb begin
		lx = (rect_left < rect_right) ? rect_left : rect_right;
		hx = (rect_left < rect_right) ? rect_right : rect_left;
		ly = (rect_top < rect_bottom) ? rect_top : rect_bottom;
		hy = (rect_top < rect_bottom) ? rect_bottom : rect_top;
		sum_x = CW'(lx) + CW'(hx) + CW'(1);
		sum_y = CW'(ly) + CW'(hy) + CW'(1);
		ext_x = CW'(hx) - CW'(lx) + CW'(1);
		ext_y = CW'(hy) - CW'(ly) + CW'(1);
	end

	// doubled midpoint terms u and v for the current region
	logic signed [YW:0] dy_x, v_s, v_abs;
	logic [MW-1:0]      u_mag, v_mag;
	logic               v_neg;
	logic [CW-1:0]      dx_inc;

	always_comb begin
		dx_inc = dx_q + CW'(1);
		dy_x   = {dy_q[YW-1], dy_q};
		if (r2_q) begin
			u_mag = {dx_q, 1'b1};
			v_s   = (dy_x - (YW+1)'(1)) <<< 1;
		end else begin
			u_mag = {dx_inc, 1'b0};
			v_s   = (dy_x <<< 1) - (YW+1)'(1);
		end
		v_neg = v_s[YW];
		v_abs = v_neg ? -v_s : v_s;
		v_mag = v_abs[MW-1:0];
	end

	// operand selection for the two multipliers
	logic [AW-1:0]  m0a, m1a;
	logic [SQW-1:0] m0b, m1b;
	logic [PW-1:0]  prod0, prod1;

	always_comb begin
		m0a = '0;
		m0b = '0;
		m1a = '0;
		m1b = '0;
		case (cmd.op)
			OP_INIT_SQ: begin
				m0a = AW'(a_q);
				m0b = SQW'(a_q);
				m1a = AW'(b_q);
				m1b = SQW'(b_q);
			end
			OP_INIT_PROD: begin
				m0a = a2_q;
				m0b = SQW'(b2_q);
			end
			OP_SQ: begin
				m0a = AW'(u_mag);
				m0b = SQW'(u_mag);
				m1a = AW'(v_mag);
				m1b = SQW'(v_mag);
			end
			OP_WT: begin
				m0a = b2_q;
				m0b = su_q;
				m1a = a2_q;
				m1b = sv_q;
			end
			OP_VEL: begin
				m0a = b2_q;
				m0b = SQW'(u_mag);
				m1a = a2_q;
				m1b = SQW'(v_mag);
			end
			default: begin
				m0a = '0;
				m0b = '0;
			end
		endcase
	end

	assign prod0 = m0a * m0b;
	assign prod1 = m1a * m1b;

	// discriminant sign from the weighted squares
	logic signed [DW-1:0] disc;

	assign disc = $signed(DW'(pu_q)) + $signed(DW'(pv_q)) - $signed(DW'(ab_q) << 2);

	// product registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INIT_SQ: begin
				a2_q <= prod0[AW-1:0];
				b2_q <= prod1[AW-1:0];
			end
			OP_INIT_PROD: begin
				ab_q <= prod0;
			end
			OP_SQ: begin
				su_q <= prod0[SQW-1:0];
				sv_q <= prod1[SQW-1:0];
			end
			OP_WT: begin
				pu_q <= prod0;
				pv_q <= prod1;
			end
			OP_VEL: begin
				vx_q   <= prod0;
				vy_q   <= prod1;
				dneg_q <= disc[DW-1];
			end
			default: begin
				dneg_q <= dneg_q;
			end
		endcase
	end

	// the four symmetric points of the current offset
	logic signed [EW-1:0] cx_e, cy_e, dx_e, dy_e;
	logic [EW-1:0]        xm, xp, ym, yp;
	logic signed [YW-1:0] dy_dec;

	always_comb begin
		cx_e   = {{(EW-CW){1'b0}}, cx_q};
		cy_e   = {{(EW-CW){1'b0}}, cy_q};
		dx_e   = {{(EW-CW){1'b0}}, dx_q};
		dy_e   = {{(EW-YW){dy_q[YW-1]}}, dy_q};
		xm     = cx_e - dx_e;
		xp     = cx_e + dx_e;
		ym     = cy_e - dy_e;
		yp     = cy_e + dy_e;
		dy_dec = dy_q - YW'(1);
	end

	// ellipse state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			a_q      <= '0;
			b_q      <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			r2_q     <= 1'b0;
			active_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					cx_q     <= sum_x >> 1;
					cy_q     <= sum_y >> 1;
					a_q      <= ext_x[CW-1:1];
					b_q      <= ext_y[CW-1:1];
					dx_q     <= '0;
					dy_q     <= $signed(YW'(ext_y[CW-1:1]));
					r2_q     <= 1'b0;
					active_q <= 1'b1;
				end
				OP_UPD: begin
					if (!r2_q) begin
						dx_q <= dx_inc;
						if (!dneg_q) begin
							dy_q <= dy_dec;
						end
						if (v_neg || vx_q >= vy_q) begin
							r2_q <= 1'b1;
						end
					end else begin
						if (dneg_q) begin
							dx_q <= dx_inc;
						end
						dy_q <= dy_dec;
						if (dy_dec[YW-1]) begin
							active_q <= 1'b0;
						end
					end
				end
				default: begin
					active_q <= active_q;
				end
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_UPD) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_UPD) begin
			out_data_q <= {yp[OUT_BITS-1:0], xp[OUT_BITS-1:0],
				yp[OUT_BITS-1:0], xm[OUT_BITS-1:0],
				ym[OUT_BITS-1:0], xp[OUT_BITS-1:0],
				ym[OUT_BITS-1:0], xm[OUT_BITS-1:0]};
			out_last_q <= r2_q && dy_dec[YW-1];
		end
	end

	assign out_valid        = out_valid_q;
	assign out_data         = out_data_q;
	assign out_last         = out_last_q;
	assign status.active    = active_q;
	assign status.slot_free = !out_valid_q || out_ready;

endmodule

[hdl/midpoint_ellipse_rasterizer.sv]
// top level of the midpoint ellipse rasterizer
//
// channel   dir  tdata                             tuser / tlast
// s_axis    in   rect_left,top,right,bottom        tuser: kind (0 start, 1 step)
// m_axis    out  px0,py0,px1,py1,px2,py2,px3,py3   tlast: last point set
//
// a step request is accepted with the squaring pass, then runs the weight,
// slope and update passes; the multiplying passes share the two multipliers
// a start request loads the rectangle, then forms the squared semi-axes and their product
// reset clears the ellipse state and leaves the block idle
// the update waits while the output register holds an untaken result

module midpoint_ellipse_rasterizer #(
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// rect_left, rect_top, rect_right, rect_bottom, zero fill
	input  logic [8*((4*COORD_BITS+7)/8)-1:0]   s_axis_tdata,
	// kind
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// px0, py0, px1, py1, px2, py2, px3, py3
	output logic [mer_pkg::OUT_W-1:0]           m_axis_tdata,
	output logic                                m_axis_tlast
);
	import mer_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencing
	mer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and state
	mer_dpath #(
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.rect_left   (s_axis_tdata[COORD_BITS-1:0]),
		.rect_top    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.rect_right  (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.rect_bottom (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_data    (m_axis_tdata),
		.out_last    (m_axis_tlast)
	);

	// an update never overwrites an untaken result
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_UPD |-> status.slot_free)
		else $error("update issued while output slot occupied");

	// after an update the result is shown and tlast matches the end of the ellipse
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_UPD |=> m_axis_tvalid && (m_axis_tlast != status.active))
		else $error("result or last flag out of step with ellipse state");

	// the squaring pass is always followed by the weight pass
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_SQ |=> cmd.op == OP_WT)
		else $error("step sequence broken after squaring pass");

endmodule
